/* hw/rtl/bga_pkg.sv */
// bga_pkg: shared types and constants for the battery gauge averager
// no dependencies; imported by the interface users, the divider and the top level
`default_nettype none

package bga_pkg;

   // fixed field widths
   localparam int RAW_W      = 12;
   localparam int MV_W       = 16;
   localparam int LEVEL_W    = 16;
   localparam int TIME_W     = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // shared divider widths: numerator holds a 12 x 16 bit product
   localparam int DIV_NUM_W  = 28;
   localparam int DIV_DEN_W  = 12;
   localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);

   // signed voltage product: 13 bit difference times 17 bit difference
   localparam int PROD_W     = 30;

   localparam logic [LEVEL_W-1:0] LEVEL_FULL = '1;
   localparam logic [LEVEL_W-1:0] LEVEL_EMPTY = '0;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RAW_MIN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RAW_MAX     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLT_MIN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLT_MAX    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_MS     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_REPORT_EN   = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM,
      ST_AVG_DIV,
      ST_LEVEL,
      ST_LEVEL_DIV,
      ST_VOLT_MUL,
      ST_VOLT_START,
      ST_VOLT_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [RAW_W-1:0]  raw_sample;
      logic [RAW_W-1:0]  charge_sense;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [MV_W-1:0]    voltage_mv;
      logic [RAW_W-1:0]   raw_value;
      logic               charging;
      logic               reports_valid;
      logic               critical;
      logic               critical_event;
   } rsp_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] numer;
      logic [DIV_DEN_W-1:0] denom;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quot;
      logic [DIV_DEN_W-1:0] rem;
   } div_rsp_type;

endpackage

`default_nettype wire

/* hw/rtl/bga_chan_if.sv */
// bga_chan_if: valid/ready channel carrying one payload word
// no dependencies; the payload type is given at instantiation
`default_nettype none

interface bga_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bga_ram.sv */
// bga_ram: generic single write port ram with registered read
// no dependencies
`default_nettype none

module bga_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                     wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* hw/rtl/bga_div.sv */
// bga_div: restoring unsigned divider, one quotient bit per cycle
// depends on bga_pkg for widths and the request/response structs
`default_nettype none

module bga_div
   import bga_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [DIV_NUM_W-1:0] quot_ff, quot_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W:0]   rem_shift;
   logic                 fits;

   assign rem_shift = {rem_ff, quot_ff[DIV_NUM_W-1]};
   assign fits      = rem_shift >= {1'b0, div_req.denom};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = DIV_CNT_W'(DIV_NUM_W - 1);
         quot_in  = div_req.numer;
         rem_in   = '0;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits the divisor width
         rem_in  = fits ? DIV_DEN_W'(rem_shift - {1'b0, div_req.denom})
                        : rem_shift[DIV_DEN_W-1:0];
         quot_in = {quot_ff[DIV_NUM_W-2:0], fits};
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

`default_nettype wire

/* hw/rtl/battery_gauge_averager.sv */
// battery_gauge_averager: top level, sequencer, sample ring and gauge datapath
// depends on bga_pkg, bga_chan_if, bga_ram and bga_div
`default_nettype none

// Battery gauge with a moving-average level. Each req word carries one ADC
// sample, a charge-sense reading and a millisecond timestamp, and gives
// exactly one rsp word. The sample goes into a ring of AVG_DEPTH entries
// (cleared at reset through per-entry valid bits); the ring average is
// scaled between raw_min and raw_max to a 16-bit level, and the instant
// sample is mapped to millivolts between volt_min_mv and volt_max_mv, both
// saturated. A voltage at or below volt_min_mv starts a low timer; after
// more than critical_hold_ms of low samples the critical flag is set and
// every further low sample raises critical_event. One 28-step restoring
// divider is shared by the average, the level and the voltage; every word
// divides the average, the level is divided only when the average lies
// strictly between raw_min and raw_max, and the voltage only when raw_max
// is above raw_min. req ready is high only while the sequencer is idle, so
// the next word is taken in the same cycle as the result at the earliest; a
// finished rsp word sits in an output register, so the next req word can be
// taken while it waits, and that word stalls in its finish step until the
// rsp register frees up. csr writes are always accepted and must only come
// while the block is idle.

module battery_gauge_averager
   import bga_pkg::*;
#(
   parameter int AVG_DEPTH   = 16,
   parameter int SAMPLE_BITS = 12
) (
   input  wire logic   clock,
   input  wire logic   reset,
   bga_chan_if.sink    req_if,
   bga_chan_if.source  rsp_if,
   bga_chan_if.sink    csr_if
);

   // samples wider than the field are impossible, narrower ones drop high bits
   localparam int SAMPLE_W = (SAMPLE_BITS < RAW_W) ? SAMPLE_BITS : RAW_W;
   localparam int PTR_W    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
   localparam int SUM_W    = SAMPLE_W + $clog2(AVG_DEPTH);
   localparam logic [PTR_W-1:0]     PTR_LAST  = PTR_W'(AVG_DEPTH - 1);
   localparam logic [DIV_DEN_W-1:0] DEPTH_DEN = DIV_DEN_W'(AVG_DEPTH);
   localparam logic [RAW_W-1:0]     SAMPLE_MAX = RAW_W'((1 << SAMPLE_W) - 1);

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [RAW_W-1:0]  raw_min_ff, raw_max_ff;
   logic [MV_W-1:0]   volt_min_ff, volt_max_ff;
   logic [TIME_W-1:0] hold_ms_ff;
   logic              report_en_ff;
   logic              csr_write;

   assign csr_if.ready = 1'b1;
   assign csr_write    = csr_if.valid & csr_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_min_ff   <= RAW_W'(0);
         raw_max_ff   <= RAW_W'(4095);
         volt_min_ff  <= MV_W'(3300);
         volt_max_ff  <= MV_W'(4200);
         hold_ms_ff   <= TIME_W'(5000);
         report_en_ff <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_if.payload.index)
            CSR_RAW_MIN:   raw_min_ff   <= csr_if.payload.data[RAW_W-1:0];
            CSR_RAW_MAX:   raw_max_ff   <= csr_if.payload.data[RAW_W-1:0];
            CSR_VOLT_MIN:  volt_min_ff  <= csr_if.payload.data[MV_W-1:0];
            CSR_VOLT_MAX:  volt_max_ff  <= csr_if.payload.data[MV_W-1:0];
            CSR_HOLD_MS:   hold_ms_ff   <= csr_if.payload.data[TIME_W-1:0];
            CSR_REPORT_EN: report_en_ff <= csr_if.payload.data[0];
            default: ; // unmapped index, write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------
   // sequencer state and datapath registers
   // ---------------------------------------------------------------
   state_type state_ff, state_in;

   logic                 req_take;
   logic                 out_free;

   // captured req word
   logic [SAMPLE_W-1:0]  raw_ff;
   logic                 charging_ff;
   logic [TIME_W-1:0]    now_ff;

   // ring bookkeeping
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [PTR_W-1:0]     ptr_ff, ptr_in;
   logic [AVG_DEPTH-1:0] valid_ff, valid_in;
   logic [SAMPLE_W-1:0]  ram_rd;
   logic [SAMPLE_W-1:0]  old_sample;
   logic                 ram_we;

   // intermediate results
   logic [RAW_W-1:0]     avg_ff, avg_in;
   logic [LEVEL_W-1:0]   level_ff, level_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   // low-voltage timer
   logic [TIME_W-1:0]    low_since_ff, low_since_in;
   logic                 low_timing_ff, low_timing_in;
   logic                 critical_ff, critical_in;
   logic                 event_now;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   div_req_type          div_req;
   div_rsp_type          div_rsp;

   assign req_take = req_if.valid & req_if.ready;
   assign out_free = ~rsp_valid_ff | rsp_if.ready;

   // ---------------------------------------------------------------
   // sample ring storage
   // ---------------------------------------------------------------
   bga_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (AVG_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ptr_ff),
      .wr_data (raw_ff),
      .rd_addr (ptr_ff),
      .rd_data (ram_rd)
   );

   // an entry never written since reset counts as zero
   assign old_sample = valid_ff[ptr_ff] ? ram_rd : '0;

   // ---------------------------------------------------------------
   // shared divider
   // ---------------------------------------------------------------
   bga_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // ---------------------------------------------------------------
   // gauge arithmetic
   // ---------------------------------------------------------------
   logic                 span_pos;
   logic                 avg_above_min, avg_below_max;
   logic                 level_div_go;
   logic [LEVEL_W-1:0]   level_sat;
   logic [RAW_W-1:0]     level_diff;
   logic [DIV_NUM_W-1:0] level_num;
   logic [DIV_DEN_W-1:0] span;

   assign span_pos      = raw_max_ff > raw_min_ff;
   assign span          = raw_max_ff - raw_min_ff;
   assign avg_above_min = avg_ff > raw_min_ff;
   assign avg_below_max = avg_ff < raw_max_ff;
   // only a strictly in-range average needs the divider
   assign level_div_go  = span_pos & avg_above_min & avg_below_max;
   assign level_sat     = (avg_above_min & (~span_pos | ~avg_below_max))
                          ? LEVEL_FULL : LEVEL_EMPTY;
   assign level_diff    = avg_ff - raw_min_ff;
   // diff * 65535 as a shift and subtract
   assign level_num     = (DIV_NUM_W'(level_diff) << LEVEL_W) - DIV_NUM_W'(level_diff);

   // voltage product: (raw - raw_min) * (volt_max - volt_min), both signed
   logic signed [RAW_W:0]  raw_delta;
   logic signed [MV_W:0]   volt_delta;
   logic                   prod_neg;
   logic [PROD_W-1:0]      prod_mag;

   assign raw_delta  = $signed({1'b0, RAW_W'(raw_ff)}) - $signed({1'b0, raw_min_ff});
   assign volt_delta = $signed({1'b0, volt_max_ff}) - $signed({1'b0, volt_min_ff});
   assign prod_in    = raw_delta * volt_delta;
   assign prod_neg   = prod_ff[PROD_W-1];
   assign prod_mag   = prod_neg ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);

   // floor division: a negative product with a remainder rounds one further down
   logic signed [DIV_NUM_W+1:0] quot_floor;
   logic signed [DIV_NUM_W+2:0] volt_wide;
   logic [MV_W-1:0]             volt_sat;
   logic [MV_W-1:0]             volt_res;
   logic                        batt_ok;

   always_comb begin
      if (prod_neg) begin
         quot_floor = -$signed({2'b00, div_rsp.quot})
                      - $signed({{(DIV_NUM_W+1){1'b0}}, div_rsp.rem != '0});
      end else begin
         quot_floor = $signed({2'b00, div_rsp.quot});
      end
      volt_wide = $signed({{(DIV_NUM_W+3-MV_W){1'b0}}, volt_min_ff})
                  + $signed({quot_floor[DIV_NUM_W+1], quot_floor});
      if (volt_wide < 0) begin
         volt_sat = '0;
      end else if (volt_wide > $signed((DIV_NUM_W+3)'(LEVEL_FULL))) begin
         volt_sat = '1;
      end else begin
         volt_sat = volt_wide[MV_W-1:0];
      end
   end

   assign volt_res = span_pos ? volt_sat : volt_min_ff;
   // ok means the exact voltage is above volt_min_mv
   assign batt_ok  = span_pos & ~prod_neg & (prod_ff != '0);

   // ---------------------------------------------------------------
   // sequencer: next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:       if (req_take) state_in = ST_SUM;
         ST_SUM:        state_in = ST_AVG_DIV;
         ST_AVG_DIV:    if (div_rsp.done) state_in = ST_LEVEL;
         ST_LEVEL:      state_in = level_div_go ? ST_LEVEL_DIV : ST_VOLT_MUL;
         ST_LEVEL_DIV:  if (div_rsp.done) state_in = ST_VOLT_MUL;
         ST_VOLT_MUL:   state_in = ST_VOLT_START;
         ST_VOLT_START: state_in = span_pos ? ST_VOLT_DIV : ST_FINISH;
         ST_VOLT_DIV:   if (div_rsp.done) state_in = ST_FINISH;
         ST_FINISH:     if (out_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------
   // sequencer: outputs to ram, divider and req channel
   // ---------------------------------------------------------------
   always_comb begin
      ram_we        = 1'b0;
      div_req.start = 1'b0;
      div_req.numer = '0;
      div_req.denom = DEPTH_DEN;
      unique case (state_ff)
         ST_SUM: begin
            ram_we        = 1'b1;
            div_req.start = 1'b1;
            div_req.numer = DIV_NUM_W'(sum_in);
            div_req.denom = DEPTH_DEN;
         end
         ST_AVG_DIV: begin
            div_req.denom = DEPTH_DEN;
         end
         ST_LEVEL: begin
            div_req.start = level_div_go;
            div_req.numer = level_num;
            div_req.denom = span;
         end
         ST_LEVEL_DIV: begin
            div_req.denom = span;
         end
         ST_VOLT_START: begin
            div_req.start = span_pos;
            div_req.numer = prod_mag[DIV_NUM_W-1:0];
            div_req.denom = span;
         end
         ST_VOLT_DIV: begin
            div_req.denom = span;
         end
         ST_IDLE, ST_VOLT_MUL, ST_FINISH: ;
         default: ;
      endcase
   end

   assign req_if.ready = (state_ff == ST_IDLE);

   // ---------------------------------------------------------------
   // datapath next values
   // ---------------------------------------------------------------
   always_comb begin
      sum_in        = sum_ff - SUM_W'(old_sample) + SUM_W'(raw_ff);
      ptr_in        = ptr_ff;
      valid_in      = valid_ff;
      avg_in        = avg_ff;
      level_in      = level_ff;
      low_since_in  = low_since_ff;
      low_timing_in = low_timing_ff;
      critical_in   = critical_ff;
      event_now     = 1'b0;
      rsp_valid_in  = rsp_valid_ff & ~rsp_if.ready;
      rsp_data_in   = rsp_data_ff;

      // low timer, used in the finish step
      if (batt_ok) begin
         low_since_in  = '0;
         low_timing_in = 1'b0;
         critical_in   = 1'b0;
      end else if (!low_timing_ff) begin
         low_timing_in = 1'b1;
         low_since_in  = now_ff;
      end else if ((now_ff - low_since_ff) > hold_ms_ff) begin
         critical_in = 1'b1;
         event_now   = 1'b1;
      end

      if (state_ff == ST_SUM) begin
         ptr_in           = (ptr_ff == PTR_LAST) ? '0 : ptr_ff + 1'b1;
         valid_in[ptr_ff] = 1'b1;
      end
      if (state_ff == ST_AVG_DIV && div_rsp.done) begin
         avg_in = div_rsp.quot[RAW_W-1:0];
      end
      if (state_ff == ST_LEVEL) begin
         level_in = level_sat;
      end
      if (state_ff == ST_LEVEL_DIV && div_rsp.done) begin
         level_in = div_rsp.quot[LEVEL_W-1:0];
      end

      rsp_data_in.level          = level_ff;
      rsp_data_in.voltage_mv     = volt_res;
      rsp_data_in.raw_value      = RAW_W'(raw_ff);
      rsp_data_in.charging       = charging_ff;
      rsp_data_in.reports_valid  = report_en_ff;
      rsp_data_in.critical       = critical_in;
      rsp_data_in.critical_event = event_now;
      if (!(state_ff == ST_FINISH && out_free)) begin
         // hold the timer and the waiting word until the finish step fires
         low_since_in  = low_since_ff;
         low_timing_in = low_timing_ff;
         critical_in   = critical_ff;
         rsp_data_in   = rsp_data_ff;
      end else begin
         rsp_valid_in = 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sum_ff        <= '0;
         ptr_ff        <= '0;
         valid_ff      <= '0;
         low_since_ff  <= '0;
         low_timing_ff <= 1'b0;
         critical_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (state_ff == ST_SUM) begin
            sum_ff <= sum_in;
         end
         ptr_ff        <= ptr_in;
         valid_ff      <= valid_in;
         low_since_ff  <= low_since_in;
         low_timing_ff <= low_timing_in;
         critical_ff   <= critical_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         raw_ff      <= req_if.payload.raw_sample[SAMPLE_W-1:0];
         charging_ff <= req_if.payload.charge_sense != '0;
         now_ff      <= req_if.payload.now_ms;
      end
      if (state_ff == ST_VOLT_MUL) begin
         prod_ff <= prod_in;
      end
      avg_ff      <= avg_in;
      level_ff    <= level_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   a_take_starts_sum: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_SUM)
      else $error("accepted word did not start the ring update");

   a_finish_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free) |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("finish step did not load the rsp register");

   a_avg_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_AVG_DIV && div_rsp.done) |=> avg_ff <= SAMPLE_MAX)
      else $error("ring average exceeds the largest sample");

   a_event_implies_critical: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.critical_event) |-> rsp_data_ff.critical)
      else $error("critical event without critical state");

endmodule

`default_nettype wire

/* verif/tb.sv */
// tb: self-checking testbench for battery_gauge_averager
// depends on bga_pkg, bga_chan_if and the battery_gauge_averager rtl
// a directed table, then random samples under several register settings

module tb
   import bga_pkg::*;
();

   localparam int RING_DEPTH = 16;
   localparam int SAMPLE_W   = 12;
   // cycle limit with room for a run of under 1k words
   localparam int unsigned CYCLE_LIMIT = 600000;
   // drain pause after the last expected word has come back
   localparam int TAIL_CYCLES = 200;

   logic clock = 1'b0;
   logic reset;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   bga_chan_if #(.payload_type(req_type)) req_ch ();
   bga_chan_if #(.payload_type(rsp_type)) rsp_ch ();
   bga_chan_if #(.payload_type(csr_type)) csr_ch ();

   battery_gauge_averager #(
      .AVG_DEPTH   (RING_DEPTH),
      .SAMPLE_BITS (SAMPLE_W)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // ------------------------------------------------------------------
   // gauge model: register copies and internal state
   // ------------------------------------------------------------------
   logic [RAW_W-1:0]  cfg_raw_min;
   logic [RAW_W-1:0]  cfg_raw_max;
   logic [MV_W-1:0]   cfg_volt_min;
   logic [MV_W-1:0]   cfg_volt_max;
   logic [TIME_W-1:0] cfg_hold_ms;
   logic              cfg_report_en;

   logic [RAW_W-1:0]                ring_model [RING_DEPTH];
   logic [$clog2(RING_DEPTH)-1:0]   ring_idx;
   logic [15:0]                     ring_total;
   logic [TIME_W-1:0]               low_start_ms;
   bit                              low_run;
   bit                              crit_held;

   rsp_type gauge_expect_q [$];

   // bookkeeping for the summary and the verdict
   int unsigned mismatch_count = 0;
   int unsigned words_sent = 0;
   int unsigned words_checked = 0;
   int unsigned crit_events_seen = 0;
   int unsigned full_levels_seen = 0;
   int unsigned setting_count = 1;
   int unsigned cycle_count = 0;

   // when set, neither side inserts idle cycles
   bit no_idle = 1'b0;

   // register write as the block sees it: fields masked to their widths,
   // unknown indexes dropped
   function automatic void apply_gauge_reg(input logic [CSR_IDX_W-1:0] idx,
                                           input logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_RAW_MIN:   cfg_raw_min   = val[RAW_W-1:0];
         CSR_RAW_MAX:   cfg_raw_max   = val[RAW_W-1:0];
         CSR_VOLT_MIN:  cfg_volt_min  = val[MV_W-1:0];
         CSR_VOLT_MAX:  cfg_volt_max  = val[MV_W-1:0];
         CSR_HOLD_MS:   cfg_hold_ms   = val[TIME_W-1:0];
         CSR_REPORT_EN: cfg_report_en = val[0];
         default: ;
      endcase
   endfunction

   // one sample in, one gauge word out; updates the ring and the low timer
   function automatic rsp_type predict_gauge(input req_type w);
      rsp_type           r;
      logic [RAW_W-1:0]  raw;
      logic [RAW_W-1:0]  avg;
      logic [TIME_W-1:0] elapsed;
      longint            lo, span, num, q, v;
      bit                ok, ev;

      raw = w.raw_sample;
      ring_total = ring_total - 16'(ring_model[ring_idx]) + 16'(raw);
      ring_model[ring_idx] = raw;
      ring_idx = ring_idx + 1'b1;
      avg = RAW_W'(ring_total / RING_DEPTH);

      lo   = longint'(cfg_raw_min);
      span = longint'(cfg_raw_max) - lo;

      // level from the ring average
      if (span <= 0)
         r.level = (avg > cfg_raw_min) ? LEVEL_FULL : LEVEL_EMPTY;
      else if (avg <= cfg_raw_min)
         r.level = LEVEL_EMPTY;
      else if (avg >= cfg_raw_max)
         r.level = LEVEL_FULL;
      else
         r.level = LEVEL_W'(((longint'(avg) - lo) * 65535) / span);

      // millivolts from the instant sample, floor division then clamp
      if (span <= 0) begin
         v  = longint'(cfg_volt_min);
         ok = 1'b0;
      end else begin
         num = (longint'(raw) - lo) *
               (longint'(cfg_volt_max) - longint'(cfg_volt_min));
         q = num / span;
         if ((num % span != 0) && (num < 0))
            q = q - 1;
         v = longint'(cfg_volt_min) + q;
         if (v < 0)
            v = 0;
         if (v > 65535)
            v = 65535;
         ok = (num > 0);
      end

      // low timer and critical state
      ev = 1'b0;
      if (ok) begin
         low_start_ms = '0;
         low_run      = 1'b0;
         crit_held    = 1'b0;
      end else if (!low_run) begin
         low_run      = 1'b1;
         low_start_ms = w.now_ms;
      end else begin
         elapsed = w.now_ms - low_start_ms;
         if (elapsed > cfg_hold_ms) begin
            crit_held = 1'b1;
            ev        = 1'b1;
         end
      end

      r.voltage_mv     = MV_W'(v);
      r.raw_value      = raw;
      r.charging       = |w.charge_sense;
      r.reports_valid  = cfg_report_en;
      r.critical       = crit_held;
      r.critical_event = ev;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------

   // offer one sample; valid stays high afterwards so a back-to-back word
   // needs no second assignment in the same step
   task automatic send_sample(input req_type w, input bit typed, input rsp_type golden);
      int      gap;
      rsp_type predicted;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= w;
      do @(posedge clock); while (!req_ch.ready);
      predicted = predict_gauge(w);
      // typed rows carry the value read straight off the spec
      gauge_expect_q.push_back(typed ? golden : predicted);
      words_sent++;
   endtask

   // register write; caller drops csr valid after the last one
   task automatic write_gauge_reg(input logic [CSR_IDX_W-1:0] idx,
                                  input logic [CSR_DATA_W-1:0] val);
      csr_ch.valid   <= 1'b1;
      csr_ch.payload <= csr_type'{index: idx, data: val};
      do @(posedge clock); while (!csr_ch.ready);
      apply_gauge_reg(idx, val);
   endtask

   // stop offering samples and wait until every word has come back
   task automatic settle_gauge();
      req_ch.valid <= 1'b0;
      while (gauge_expect_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // reprogram all registers while idle, then stream random samples
   task automatic run_phase(input logic [RAW_W-1:0] rmin, input logic [RAW_W-1:0] rmax,
                            input logic [MV_W-1:0] vmin, input logic [MV_W-1:0] vmax,
                            input logic [TIME_W-1:0] hold, input logic ren,
                            input int count, input bit rush);
      int unsigned       step_cap;
      int unsigned       streak_left;
      bit                streak_low;
      int unsigned       sel;
      logic [RAW_W-1:0]  raw;
      logic [RAW_W-1:0]  charge;
      logic [TIME_W-1:0] time_ms;
      req_type           w;

      settle_gauge();

      // unused indexes first and last, with junk above each narrower field
      write_gauge_reg(3'd6, $urandom);
      write_gauge_reg(CSR_RAW_MIN,   {20'($urandom), rmin});
      write_gauge_reg(CSR_RAW_MAX,   {20'($urandom), rmax});
      write_gauge_reg(CSR_VOLT_MIN,  {16'($urandom), vmin});
      write_gauge_reg(CSR_VOLT_MAX,  {16'($urandom), vmax});
      write_gauge_reg(CSR_HOLD_MS,   hold);
      write_gauge_reg(CSR_REPORT_EN, {31'($urandom), ren});
      write_gauge_reg(3'd7, $urandom);
      csr_ch.valid <= 1'b0;
      setting_count++;
      no_idle = rush;

      // time steps scaled so several low samples cross the hold time
      step_cap = cfg_hold_ms / 3;
      if (step_cap < 1)
         step_cap = 1;
      if (step_cap > 4000)
         step_cap = 4000;
      streak_left = 0;
      streak_low  = 1'b0;
      time_ms     = $urandom;

      for (int n = 0; n < count; n++) begin
         // alternate runs of low samples with runs of mixed samples
         if (streak_left == 0) begin
            streak_low  = ($urandom_range(0, 1) == 1);
            streak_left = streak_low ? $urandom_range(2, 12) : $urandom_range(1, 6);
         end
         streak_left--;

         if (streak_low) begin
            // a sample that the ok test rejects under the current slope
            if (cfg_volt_max > cfg_volt_min)
               raw = RAW_W'($urandom_range(0, cfg_raw_min));
            else if (cfg_volt_max < cfg_volt_min)
               raw = RAW_W'($urandom_range(cfg_raw_min, 4095));
            else
               raw = RAW_W'($urandom_range(0, 4095));
         end else begin
            sel = $urandom_range(0, 9);
            case (sel)
               0: raw = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
               1, 2: raw = (cfg_raw_min == 12'hFFF) ? cfg_raw_min :
                           cfg_raw_min + RAW_W'($urandom_range(0, 1));
               3: raw = (cfg_raw_max == 12'h000) ? cfg_raw_max :
                        cfg_raw_max - RAW_W'($urandom_range(0, 1));
               default: raw = RAW_W'($urandom_range(0, 4095));
            endcase
         end

         charge = $urandom_range(0, 1) ? 12'h000 : RAW_W'($urandom_range(1, 4095));

         sel = $urandom_range(0, 19);
         if (sel == 0)
            time_ms = $urandom;                          // jump anywhere
         else if (sel < 3)
            time_ms = time_ms + cfg_hold_ms + $urandom_range(0, 2) - 1;
         else
            time_ms = time_ms + $urandom_range(0, step_cap);

         w = req_type'{raw_sample: raw, charge_sense: charge, now_ms: time_ms};
         send_sample(w, 1'b0, '0);
      end
   endtask

   // typed expectation for the low-battery rows of the directed table:
   // empty level, voltage at the default minimum, reports on
   function automatic rsp_type low_rsp(input logic [RAW_W-1:0] raw,
                                       input logic chg, input logic crit);
      return rsp_type'{level: LEVEL_EMPTY, voltage_mv: 16'd3300, raw_value: raw,
                       charging: chg, reports_valid: 1'b1,
                       critical: crit, critical_event: crit};
   endfunction

   typedef struct {
      req_type word;
      bit      typed;
      rsp_type golden;
   } gauge_row_type;

   gauge_row_type gauge_rows [$];

   // ------------------------------------------------------------------
   // result side: random backpressure and checking against the queue
   // ------------------------------------------------------------------
   int unsigned rsp_stall;

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t  %s: expected %0d, got %0d", $time, name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type     want;
      rsp_type     got;
      int unsigned s;
      if (reset) begin
         rsp_ch.ready <= 1'b1;
         rsp_stall    <= 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.payload;
         if (gauge_expect_q.size() == 0) begin
            $display("%0t  unexpected gauge word: level %0d voltage %0d raw %0d",
                     $time, got.level, got.voltage_mv, got.raw_value);
            mismatch_count++;
         end else begin
            want = gauge_expect_q.pop_front();
            check_field("level",          want.level,          got.level);
            check_field("voltage_mv",     want.voltage_mv,     got.voltage_mv);
            check_field("raw_value",      want.raw_value,      got.raw_value);
            check_field("charging",       want.charging,       got.charging);
            check_field("reports_valid",  want.reports_valid,  got.reports_valid);
            check_field("critical",       want.critical,       got.critical);
            check_field("critical_event", want.critical_event, got.critical_event);
            words_checked++;
            if (want.critical_event)
               crit_events_seen++;
            if (want.level == LEVEL_FULL)
               full_levels_seen++;
         end
         // stall count for the next word, counted only while it is offered
         s = no_idle ? 0 : $urandom_range(0, 4);
         rsp_ch.ready <= (s == 0);
         rsp_stall    <= s;
      end else if (rsp_ch.valid && rsp_stall != 0) begin
         rsp_stall    <= rsp_stall - 1;
         rsp_ch.ready <= (rsp_stall == 1);
      end
   end

   // ------------------------------------------------------------------
   // watchdog
   // ------------------------------------------------------------------
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d words outstanding",
               cycle_count, gauge_expect_q.size());
      $display("Mismatches found");
      $finish;
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      logic [RAW_W-1:0]  rmin, rmax;
      logic [TIME_W-1:0] hold;

      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      csr_ch.valid   <= 1'b0;
      csr_ch.payload <= '0;

      // model state after reset
      cfg_raw_min   = 12'd0;
      cfg_raw_max   = 12'd4095;
      cfg_volt_min  = 16'd3300;
      cfg_volt_max  = 16'd4200;
      cfg_hold_ms   = 32'd5000;
      cfg_report_en = 1'b1;
      foreach (ring_model[k])
         ring_model[k] = '0;
      ring_idx     = '0;
      ring_total   = '0;
      low_start_ms = '0;
      low_run      = 1'b0;
      crit_held    = 1'b0;

      // directed table at reset settings; ring starts at zero so the first
      // rows have an empty level
      // timer started just before the 32-bit wrap, expiry measured across it
      gauge_rows.push_back('{req_type'{12'h000, 12'h000, 32'hFFFF_F000}, 1'b1,
                             low_rsp(12'h000, 1'b0, 1'b0)});
      // exactly the hold time: not yet critical
      gauge_rows.push_back('{req_type'{12'h000, 12'h001, 32'h0000_0388}, 1'b1,
                             low_rsp(12'h000, 1'b1, 1'b0)});
      // one past the hold time: critical with event
      gauge_rows.push_back('{req_type'{12'h000, 12'h800, 32'h0000_0389}, 1'b1,
                             low_rsp(12'h000, 1'b1, 1'b1)});
      // still low: event repeats
      gauge_rows.push_back('{req_type'{12'h000, 12'h000, 32'h0000_0389}, 1'b1,
                             low_rsp(12'h000, 1'b0, 1'b1)});
      // one count above raw_min: voltage rounds to the minimum but counts as ok
      gauge_rows.push_back('{req_type'{12'h001, 12'h000, 32'h0000_0400}, 1'b1,
                             low_rsp(12'h001, 1'b0, 1'b0)});
      // timer start at time zero is a real start
      gauge_rows.push_back('{req_type'{12'h000, 12'h000, 32'h0000_0000}, 1'b1,
                             low_rsp(12'h000, 1'b0, 1'b0)});
      gauge_rows.push_back('{req_type'{12'h000, 12'h000, 32'h0000_1388}, 1'b1,
                             low_rsp(12'h000, 1'b0, 1'b0)});
      gauge_rows.push_back('{req_type'{12'h000, 12'h000, 32'h0000_1389}, 1'b1,
                             low_rsp(12'h000, 1'b0, 1'b1)});
      // full-scale and patterned samples, checked by the model
      gauge_rows.push_back('{req_type'{12'hFFF, 12'hFFF, 32'hFFFF_FFFF}, 1'b0, '0});
      gauge_rows.push_back('{req_type'{12'h800, 12'h000, 32'h0000_0000}, 1'b0, '0});
      gauge_rows.push_back('{req_type'{12'hAAA, 12'h555, 32'hAAAA_AAAA}, 1'b0, '0});
      gauge_rows.push_back('{req_type'{12'h555, 12'hAAA, 32'h5555_5555}, 1'b0, '0});
      gauge_rows.push_back('{req_type'{12'h7FF, 12'h001, 32'h7FFF_FFFF}, 1'b0, '0});
      gauge_rows.push_back('{req_type'{12'hFFF, 12'h000, 32'h8000_0000}, 1'b0, '0});
      gauge_rows.push_back('{req_type'{12'h000, 12'h000, 32'h8000_0000}, 1'b0, '0});
      gauge_rows.push_back('{req_type'{12'hFFF, 12'hFFF, 32'h8000_1000}, 1'b0, '0});

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (gauge_rows[k])
         send_sample(gauge_rows[k].word, gauge_rows[k].typed, gauge_rows[k].golden);

      // widest span, zero hold time, reports off
      run_phase(12'd0, 12'd4095, 16'd0, 16'd65535, 32'd0, 1'b0, 100, 1'b0);
      // reversed span, hold can never expire
      run_phase(12'd4095, 12'd0, 16'd65535, 16'd0, 32'hFFFF_FFFF, 1'b1, 80, 1'b0);
      // empty span
      run_phase(12'd2048, 12'd2048, 16'd3300, 16'd4200, 32'd100, 1'b1, 80, 1'b1);
      // one-count span with falling voltage: floor on negatives, both clamps
      run_phase(12'd1000, 12'd1001, 16'd65535, 16'd0, 32'd50, 1'b0, 100, 1'b0);
      // steep rising slope that saturates high
      run_phase(12'd0, 12'd1, 16'd65000, 16'd65535, 32'd3000, 1'b1, 100, 1'b0);

      // random settings, mostly sane spans and short hold times
      for (int p = 0; p < 4; p++) begin
         rmin = RAW_W'($urandom_range(0, 4095));
         rmax = ($urandom_range(0, 9) < 7) ? RAW_W'($urandom_range(rmin, 4095))
                                           : RAW_W'($urandom_range(0, 4095));
         hold = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 20000) : $urandom;
         run_phase(rmin, rmax, MV_W'($urandom), MV_W'($urandom), hold,
                   1'($urandom), 100, (p == 2));
      end

      // back to the reset values
      run_phase(12'd0, 12'd4095, 16'd3300, 16'd4200, 32'd5000, 1'b1, 60, 1'b0);

      req_ch.valid <= 1'b0;
      while (gauge_expect_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (gauge_expect_q.size() != 0) begin
         $display("%0d gauge words never arrived", gauge_expect_q.size());
         mismatch_count++;
      end

      $display("ran %0d samples over %0d register settings, %0d gauge words checked",
               words_sent, setting_count, words_checked);
      $display("saw %0d critical events and %0d full-scale levels",
               crit_events_seen, full_levels_seen);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
